>>> hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sorted list engine: item kinds, result
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    localparam int ITEM_W   = 8;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_DUMP   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_START,
        OP_ROTATE
    } dp_op_t;

    // controller -> datapath
    typedef struct packed {
        dp_op_t  op;
        logic    load;
        status_t res_status;
        logic    use_head;
        logic    res_last;
    } sle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic dump_last;
    } sle_stat_t;

endpackage

`default_nettype wire

>>> hdl/sorted_list_engine.sv
// An accepted insert or remove gives its result beat in the next cycle.
// Throughput: one insert or remove per cycle when the result is not stalled;
// every entry cell compares in parallel. A dump stalls the input until its last
// beat is loaded, one result beat per cycle while unstalled, from the rotating head.
// Reset clears the fill count, the controller and the result valid; entry cells
// are not reset and are never read before they are written.
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded list of bytes kept in ascending order with insert, remove and
// in-order dump.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire logic [1:0]          kind,
    input  wire logic [ITEM_W-1:0]   value,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output logic [1:0]               status,
    output logic [ITEM_W-1:0]        item,
    output logic [COUNT_W-1:0]       count,
    output logic                     last
);

    sle_cmd_t  cmd;
    sle_stat_t stat;

    sle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .kind      (kind),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .stat   (stat),
        .status (status),
        .item   (item),
        .count  (count),
        .last   (last)
    );

endmodule

`default_nettype wire

>>> hdl/sle_dp.sv
// ----------------------------------------------------------------------------
// sle_dp
// Datapath: a row of entry cells that compare against the incoming value
// in parallel and shift together, the fill and dump counters, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_dp
    import sle_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [ITEM_W-1:0]   value,
    input  wire sle_cmd_t            cmd,
    output sle_stat_t                stat,
    output logic [1:0]               status,
    output logic [ITEM_W-1:0]        item,
    output logic [COUNT_W-1:0]       count,
    output logic                     last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ITEM_W-1:0] entries_reg  [DEPTH];
    logic [ITEM_W-1:0] entries_next [DEPTH];
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  fill_top;

    logic [DEPTH-1:0]  sh_vec;
    logic [DEPTH-1:0]  eq_vec;
    logic [DEPTH-1:0]  at_vec;

    logic [1:0]         status_reg;
    logic [ITEM_W-1:0]  item_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;

    assign fill_top = fill_reg - CNT_W'(1);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX      = CNT_W'(i);
        localparam logic [DEPTH-1:0] LOW_MASK = {DEPTH{1'b1}} >> (DEPTH - 1 - i);

        logic              below;
        logic [ITEM_W-1:0] prev_val;
        logic              prev_sh;
        logic [ITEM_W-1:0] succ_val;

        assign below     = IDX < fill_reg;
        // shift point: cells at or after the first entry >= value, plus the free slot
        assign sh_vec[i] = (below && entries_reg[i] >= value) || (IDX == fill_reg);
        assign eq_vec[i] = below && (entries_reg[i] == value);
        // at or after the first matching entry
        assign at_vec[i] = |(eq_vec & LOW_MASK);

        if (i == 0) begin : g_first
            assign prev_val = value;
            assign prev_sh  = 1'b0;
        end
        else begin : g_mid
            assign prev_val = entries_reg[i-1];
            assign prev_sh  = sh_vec[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign succ_val = entries_reg[i];
        end
        else begin : g_body
            assign succ_val = entries_reg[i+1];
        end

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            case (cmd.op)
                OP_INSERT:
                begin
                    if (sh_vec[i])
                    begin
                        entries_next[i] = prev_sh ? prev_val : value;
                    end
                end
                OP_REMOVE:
                begin
                    if (at_vec[i])
                    begin
                        entries_next[i] = succ_val;
                    end
                end
                OP_ROTATE:
                begin
                    // wrap the head into the last valid slot
                    entries_next[i] = (IDX == fill_top) ? entries_reg[0] : succ_val;
                end
                default:
                begin
                    entries_next[i] = entries_reg[i];
                end
            endcase
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        rem_next  = rem_reg;
        case (cmd.op)
            OP_INSERT: fill_next = fill_reg + CNT_W'(1);
            OP_REMOVE: fill_next = fill_reg - CNT_W'(1);
            OP_START:  rem_next  = fill_reg;
            OP_ROTATE: rem_next  = rem_reg - CNT_W'(1);
            default:
            begin
                fill_next = fill_reg;
                rem_next  = rem_reg;
            end
        endcase
    end

    assign stat.full      = fill_reg == CNT_W'(DEPTH);
    assign stat.empty     = fill_reg == '0;
    assign stat.found     = |eq_vec;
    assign stat.dump_last = rem_reg == CNT_W'(1);

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        if (cmd.load)
        begin
            status_reg <= cmd.res_status;
            item_reg   <= cmd.use_head ? entries_reg[0] : '0;
            count_reg  <= COUNT_W'(fill_next);
            last_reg   <= cmd.res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            rem_reg  <= rem_next;
        end
    end

    assign status = status_reg;
    assign item   = item_reg;
    assign count  = count_reg;
    assign last   = last_reg;

endmodule

`default_nettype wire

>>> hdl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: input and result handshakes, dispatch of insert, remove and
// dump items, and the dump walk of the list, one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ctrl
    import sle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire logic [1:0] kind,
    output logic            res_valid,
    input  wire logic       res_stall,
    input  wire sle_stat_t  stat,
    output sle_cmd_t        cmd
);

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    // result register can take a beat this cycle
    assign out_free = !valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.load       = 1'b0;
        cmd.res_status = STAT_OK;
        cmd.use_head   = 1'b0;
        cmd.res_last   = 1'b1;
        cmd_stall      = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = !out_free;
                if (cmd_valid && out_free)
                begin
                    unique case (kind_t'(kind))
                        KIND_INSERT:
                        begin
                            cmd.load       = 1'b1;
                            cmd.op         = stat.full ? OP_NONE : OP_INSERT;
                            cmd.res_status = stat.full ? STAT_FULL : STAT_OK;
                        end
                        KIND_REMOVE:
                        begin
                            cmd.load       = 1'b1;
                            cmd.op         = stat.found ? OP_REMOVE : OP_NONE;
                            cmd.res_status = stat.found ? STAT_OK : STAT_NOT_FOUND;
                        end
                        KIND_DUMP:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load       = 1'b1;
                                cmd.res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.op     = OP_START;
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            // drop unused kind codes
                            cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    cmd.op       = OP_ROTATE;
                    cmd.load     = 1'b1;
                    cmd.use_head = 1'b1;
                    cmd.res_last = stat.dump_last;
                    if (stat.dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign valid_next = cmd.load || (valid_reg && res_stall);
    assign res_valid  = valid_reg;

endmodule

`default_nettype wire

>>> hdl/sle_check.sv
// ----------------------------------------------------------------------------
// sle_check
// Port-level checks for the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_check
    import sle_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                res_valid,
    input wire logic                res_stall,
    input wire logic [1:0]          status,
    input wire logic [ITEM_W-1:0]   item,
    input wire logic [COUNT_W-1:0]  count,
    input wire logic                last
);

    // a stalled beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(item)
            && $stable(count) && $stable(last))
        else $error("result beat changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == STAT_FULL |-> count == COUNT_W'(DEPTH) && last)
        else $error("full status with list not at capacity");

    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == STAT_EMPTY |-> count == '0 && item == '0 && last)
        else $error("malformed empty-list beat");

    a_item_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && item != '0 |-> status == STAT_OK && count != '0)
        else $error("nonzero item outside a dump beat");

endmodule

bind sorted_list_engine sle_check #(.DEPTH(DEPTH)) u_sle_check (.*);

`default_nettype wire

>>> test/tb_sorted_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_engine
// Self-checking bench for the sorted list engine. A queue-fed driver sends
// insert, remove, dump and unused-code beats. A shadow sorted list predicts
// every result beat. The monitor compares each accepted result beat field by
// field with the oldest prediction. Phases vary sender idling and receiver
// stalling.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine;
    import sle_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef enum int {
        RUN_FILL,
        RUN_NARROW,
        RUN_WIDE
    } run_style_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ITEM_W-1:0] value;
    } list_cmd_t;

    typedef struct packed {
        status_t            status;
        logic [ITEM_W-1:0]  item;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    logic [1:0]         kind = '0;
    logic [ITEM_W-1:0]  value = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic [1:0]         status;
    logic [ITEM_W-1:0]  item;
    logic [COUNT_W-1:0] count;
    logic               last;

    list_cmd_t         pending_cmds[$];
    result_beat_t      expected_beats[$];
    logic [ITEM_W-1:0] sorted_bytes[$];
    logic              cmd_taken = 1'b0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatch_count = 0;

    sorted_list_engine #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .kind(kind),
        .value(value),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .status(status),
        .item(item),
        .count(count),
        .last(last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the shadow list for one accepted command and queue its result beats.
    function automatic void predict_list_op(input logic [1:0] op_kind,
                                            input logic [ITEM_W-1:0] op_value);
        int pos;
        result_beat_t beat;
        pos = 0;
        beat.status = STAT_OK;
        beat.item = '0;
        beat.count = '0;
        beat.last = 1'b1;
        case (op_kind)
            KIND_INSERT:
            begin
                if (sorted_bytes.size() >= DEPTH)
                    beat.status = STAT_FULL;
                else
                begin
                    while (pos < sorted_bytes.size() && op_value > sorted_bytes[pos])
                        pos++;
                    sorted_bytes.insert(pos, op_value);
                end
                beat.count = COUNT_W'(sorted_bytes.size());
                expected_beats.push_back(beat);
            end
            KIND_REMOVE:
            begin
                while (pos < sorted_bytes.size() && sorted_bytes[pos] != op_value)
                    pos++;
                if (pos >= sorted_bytes.size())
                    beat.status = STAT_NOT_FOUND;
                else
                    sorted_bytes.delete(pos);
                beat.count = COUNT_W'(sorted_bytes.size());
                expected_beats.push_back(beat);
            end
            KIND_DUMP:
            begin
                if (sorted_bytes.size() == 0)
                begin
                    beat.status = STAT_EMPTY;
                    expected_beats.push_back(beat);
                end
                else
                begin
                    foreach (sorted_bytes[i])
                    begin
                        beat.item = sorted_bytes[i];
                        beat.count = COUNT_W'(sorted_bytes.size());
                        beat.last = (i == sorted_bytes.size() - 1);
                        expected_beats.push_back(beat);
                    end
                end
            end
            default:
            begin
                // unused code: drop silently
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : monitor
        result_beat_t seen;
        result_beat_t want;
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            predict_list_op(kind, value);
        if (rst_n && res_valid && !res_stall)
        begin
            seen.status = status_t'(status);
            seen.item = item;
            seen.count = count;
            seen.last = last;
            if (expected_beats.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result beat status %0d item %02h %s",
                             $time, seen.status, seen.item,
                             $sformatf("count %0d last %0d", seen.count, seen.last));
            end
            else
            begin
                want = expected_beats.pop_front();
                if (seen.status !== want.status || seen.item !== want.item ||
                    seen.count !== want.count || seen.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result mismatch exp %s, got %s", $time,
                                 $sformatf("st %0d it %02h cnt %0d last %0d",
                                           want.status, want.item, want.count,
                                           want.last),
                                 $sformatf("st %0d it %02h cnt %0d last %0d",
                                           seen.status, seen.item, seen.count,
                                           seen.last));
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        list_cmd_t next_cmd;
        res_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (cmd_valid && !cmd_taken)
        begin
            // hold the stalled beat
        end
        else if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            next_cmd = pending_cmds.pop_front();
            cmd_valid <= 1'b1;
            kind <= next_cmd.kind;
            value <= next_cmd.value;
        end
        else
            cmd_valid <= 1'b0;
    end

    task automatic push_cmd(input logic [1:0] cmd_kind, input logic [ITEM_W-1:0] cmd_value);
        list_cmd_t cmd;
        cmd.kind = cmd_kind;
        cmd.value = cmd_value;
        pending_cmds.push_back(cmd);
    endtask

    task automatic queue_run(input run_style_t style, input int n);
        int roll;
        logic [1:0] cmd_kind;
        logic [ITEM_W-1:0] cmd_value;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            cmd_value = (style == RUN_NARROW) ? ITEM_W'($urandom_range(15))
                                              : ITEM_W'($urandom_range(255));
            if (style == RUN_FILL || roll < 45)
                cmd_kind = KIND_INSERT;
            else if (roll < 85)
                cmd_kind = KIND_REMOVE;
            else if (roll < 96)
                cmd_kind = KIND_DUMP;
            else
                cmd_kind = KIND_UNUSED;
            push_cmd(cmd_kind, cmd_value);
        end
    endtask

    // Remove every held entry in shuffled order; call only when drained.
    task automatic queue_clear_list();
        logic [ITEM_W-1:0] victims[$];
        victims = sorted_bytes;
        victims.shuffle();
        foreach (victims[i])
            push_cmd(KIND_REMOVE, victims[i]);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || (cmd_valid && !cmd_taken) ||
               expected_beats.size() != 0);
    endtask

    initial
    begin : stimulus
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // no idling: corner cases, then fill past full
        push_cmd(KIND_DUMP, 8'h00);
        push_cmd(KIND_REMOVE, 8'h05);
        push_cmd(KIND_INSERT, 8'hFF);
        push_cmd(KIND_INSERT, 8'h00);
        push_cmd(KIND_INSERT, 8'h80);
        push_cmd(KIND_INSERT, 8'h80);
        push_cmd(KIND_INSERT, 8'h7F);
        push_cmd(KIND_DUMP, 8'hFF);
        push_cmd(KIND_REMOVE, 8'h80);
        push_cmd(KIND_REMOVE, 8'h07);
        push_cmd(KIND_UNUSED, 8'hAA);
        push_cmd(KIND_UNUSED, 8'h55);
        push_cmd(KIND_DUMP, 8'h5A);
        push_cmd(KIND_REMOVE, 8'h00);
        push_cmd(KIND_REMOVE, 8'hFF);
        push_cmd(KIND_REMOVE, 8'h7F);
        push_cmd(KIND_REMOVE, 8'h80);
        push_cmd(KIND_DUMP, 8'hA5);
        queue_run(RUN_FILL, DEPTH + 2);
        push_cmd(KIND_DUMP, 8'h00);
        queue_run(RUN_WIDE, 10);
        wait_drained();

        // sender idles
        send_idle_pct = 67;
        queue_clear_list();
        push_cmd(KIND_DUMP, 8'h00);
        queue_run(RUN_NARROW, 20);
        wait_drained();

        // receiver stalls
        send_idle_pct = 0;
        recv_stall_pct = 67;
        queue_run(RUN_WIDE, 15);
        push_cmd(KIND_DUMP, 8'hFF);
        wait_drained();

        // both sides idle now and then
        send_idle_pct = 11;
        recv_stall_pct = 11;
        queue_clear_list();
        queue_run(RUN_NARROW, 15);
        push_cmd(KIND_DUMP, 8'h00);
        wait_drained();

        // let any stray beat surface before judging
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (3 * DEPTH) @(negedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
